### rtl/core/bfea_pkg.sv
// Shared widths, register indexes and fixed limits for the Bezier fit error accumulator.
// No dependencies; every other file of the block imports this package.
package bfea_pkg;

  // Field widths of the sample and result beats.
  localparam int COORD_W   = 32;
  localparam int T_IN_W    = 17;
  localparam int SUM_W     = 47;

  // Configuration port.
  localparam int CFG_IDX_W = 3;

  // Shared multiplier: signed operands, full-width product.
  localparam int MUL_W     = COORD_W + 1;
  localparam int PROD_W    = 2 * MUL_W;

  // Sum of two squares of 32-bit magnitudes, and its floor square root.
  localparam int SQ_W      = 2 * COORD_W + 1;
  localparam int ROOT_W    = COORD_W + 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd7;

endpackage

### rtl/core/bfea_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on bfea_pkg for the field widths.
interface bfea_sample_if import bfea_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [T_IN_W-1:0]         t_value;
  logic                      last;

  modport source (output valid, output point_x, output point_y, output t_value,
                  output last, input ready);
  modport sink   (input valid, input point_x, input point_y, input t_value,
                  input last, output ready);
endinterface

interface bfea_result_if import bfea_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] error_sum;
  logic             saturated;

  modport source (output valid, output error_sum, output saturated, input ready);
  modport sink   (input valid, input error_sum, input saturated, output ready);
endinterface

### rtl/core/bezier_fit_error_accumulator_unit.sv
// Top level of the Bezier fit error accumulator: config registers, sequencer,
// shared multiplier datapath and saturating sum. Depends on bfea_pkg, bfea_if,
// bfea_mul and bfea_isqrt.
//
//   channel   dir   handshake      payload
//   sample    in    valid/ready    point_x, point_y, t_value, last
//   result    out   valid/ready    error_sum, saturated
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// Each sample is accepted, then runs 19 sequencer steps that share one
// 33x33 multiplier for the Bernstein weights, both coordinates and both squares,
// then passes through the square root unit (one bit pair a cycle, then its
// done flag) and an add step.
// Reset is synchronous and clears the sum, the flag and the config registers.
// A finished result waits in the output register; only a second last-marked
// sample that finishes while it is still held stalls in the add step.
module bezier_fit_error_accumulator_unit import bfea_pkg::*; #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  bfea_sample_if.sink          sample,
  bfea_result_if.source        result
);

  localparam int TW     = T_FRAC_BITS + 1;
  localparam int WW     = T_FRAC_BITS + 3;
  localparam int ACC_W  = COORD_W + TW + 1;
  localparam int CX_W   = ACC_W - T_FRAC_BITS;
  localparam int STEP_W = 5;
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  // Sequencer steps: most issue one product, and most store the one from the previous step.
  localparam logic [STEP_W-1:0] ST_UU   = 5'd0;
  localparam logic [STEP_W-1:0] ST_TT   = 5'd1;
  localparam logic [STEP_W-1:0] ST_W0   = 5'd2;
  localparam logic [STEP_W-1:0] ST_W1   = 5'd3;
  localparam logic [STEP_W-1:0] ST_W2   = 5'd4;
  localparam logic [STEP_W-1:0] ST_W3   = 5'd5;
  localparam logic [STEP_W-1:0] ST_X0   = 5'd6;
  localparam logic [STEP_W-1:0] ST_X1   = 5'd7;
  localparam logic [STEP_W-1:0] ST_X2   = 5'd8;
  localparam logic [STEP_W-1:0] ST_X3   = 5'd9;
  localparam logic [STEP_W-1:0] ST_Y0   = 5'd10;
  localparam logic [STEP_W-1:0] ST_Y1   = 5'd11;
  localparam logic [STEP_W-1:0] ST_Y2   = 5'd12;
  localparam logic [STEP_W-1:0] ST_Y3   = 5'd13;
  localparam logic [STEP_W-1:0] ST_SQX  = 5'd14;
  localparam logic [STEP_W-1:0] ST_AY   = 5'd15;
  localparam logic [STEP_W-1:0] ST_SQY  = 5'd16;
  localparam logic [STEP_W-1:0] ST_SUM  = 5'd17;
  localparam logic [STEP_W-1:0] ST_ROOT = 5'd18;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MUL    = 4'b0010,
    S_ROOT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  logic [STEP_W-1:0] step;

  // Curve control points.
  logic signed [COORD_W-1:0] start_x, start_y, ctrl1_x, ctrl1_y;
  logic signed [COORD_W-1:0] ctrl2_x, ctrl2_y, end_x, end_y;

  // Per-sample working registers.
  logic signed [COORD_W-1:0] px, py;
  logic [TW-1:0]             t_q;
  logic                      last_q;
  logic [TW-1:0]             u2, t2;
  logic [WW-1:0]             w0, w1, w2, w3;
  logic signed [ACC_W-1:0]   acc;
  logic [COORD_W-1:0]        ax, ay;
  logic [SQ_W-1:0]           sq;

  logic [SUM_W-1:0] running_sum;
  logic             overflow_seen;

  logic [TW-1:0]              u;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic [WW-1:0]              wq, w_tri;
  logic signed [CX_W-1:0]     acc_hi, dxy;
  logic signed [COORD_W-1:0]  pq;
  logic [COORD_W-1:0]         abs_d;

  logic              root_start, root_busy, root_done;
  logic [ROOT_W-1:0] root_val;
  logic [SUM_W:0]    sum_add;
  logic              sum_sat;
  logic [SUM_W-1:0]  sum_new;
  logic              out_free;

  assign u          = T_ONE - t_q;
  assign root_start = (state == S_MUL) && (step == ST_ROOT);
  assign out_free   = !result.valid || result.ready;
  assign sample.ready = (state == S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0; start_y <= '0; ctrl1_x <= '0; ctrl1_y <= '0;
      ctrl2_x <= '0; ctrl2_y <= '0; end_x <= '0; end_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X: start_x <= cfg_data;
        REG_START_Y: start_y <= cfg_data;
        REG_CTRL1_X: ctrl1_x <= cfg_data;
        REG_CTRL1_Y: ctrl1_y <= cfg_data;
        REG_CTRL2_X: ctrl2_x <= cfg_data;
        REG_CTRL2_Y: ctrl2_y <= cfg_data;
        REG_END_X:   end_x   <= cfg_data;
        REG_END_Y:   end_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      ST_UU:  begin mul_a = MUL_W'($signed({1'b0, u}));  mul_b = MUL_W'($signed({1'b0, u})); end
      ST_TT:  begin mul_a = MUL_W'($signed({1'b0, t_q})); mul_b = MUL_W'($signed({1'b0, t_q})); end
      ST_W0:  begin mul_a = MUL_W'($signed({1'b0, u2})); mul_b = MUL_W'($signed({1'b0, u})); end
      ST_W1:  begin mul_a = MUL_W'($signed({1'b0, u2})); mul_b = MUL_W'($signed({1'b0, t_q})); end
      ST_W2:  begin mul_a = MUL_W'($signed({1'b0, t2})); mul_b = MUL_W'($signed({1'b0, u})); end
      ST_W3:  begin mul_a = MUL_W'($signed({1'b0, t2})); mul_b = MUL_W'($signed({1'b0, t_q})); end
      ST_X0:  begin mul_a = MUL_W'($signed({1'b0, w0})); mul_b = MUL_W'(start_x); end
      ST_X1:  begin mul_a = MUL_W'($signed({1'b0, w1})); mul_b = MUL_W'(ctrl1_x); end
      ST_X2:  begin mul_a = MUL_W'($signed({1'b0, w2})); mul_b = MUL_W'(ctrl2_x); end
      ST_X3:  begin mul_a = MUL_W'($signed({1'b0, w3})); mul_b = MUL_W'(end_x); end
      ST_Y0:  begin mul_a = MUL_W'($signed({1'b0, w0})); mul_b = MUL_W'(start_y); end
      ST_Y1:  begin mul_a = MUL_W'($signed({1'b0, w1})); mul_b = MUL_W'(ctrl1_y); end
      ST_Y2:  begin mul_a = MUL_W'($signed({1'b0, w2})); mul_b = MUL_W'(ctrl2_y); end
      ST_Y3:  begin mul_a = MUL_W'($signed({1'b0, w3})); mul_b = MUL_W'(end_y); end
      ST_SQX: begin mul_a = MUL_W'($signed({1'b0, ax})); mul_b = MUL_W'($signed({1'b0, ax})); end
      ST_SQY: begin mul_a = MUL_W'($signed({1'b0, ay})); mul_b = MUL_W'($signed({1'b0, ay})); end
      default: ;
    endcase
  end

  bfea_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Weight scaling, and the distance of one coordinate from the curve point.
  always_comb begin
    wq     = WW'(prod[T_FRAC_BITS +: TW]);
    w_tri  = wq + {wq[WW-2:0], 1'b0};
    acc_hi = acc[ACC_W-1:T_FRAC_BITS];
    pq     = (step == ST_Y1) ? px : py;
    dxy    = CX_W'(pq) - acc_hi;
    abs_d  = dxy[CX_W-1] ? COORD_W'(-dxy) : COORD_W'(dxy);
  end

  // Store the product issued in the previous step.
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      case (step)
        ST_TT:  u2 <= prod[T_FRAC_BITS +: TW];
        ST_W0:  t2 <= prod[T_FRAC_BITS +: TW];
        ST_W1:  w0 <= wq;
        ST_W2:  w1 <= w_tri;
        ST_W3:  w2 <= w_tri;
        ST_X0:  w3 <= wq;
        ST_X1:  acc <= ACC_W'(prod);
        ST_X2, ST_X3, ST_Y0: acc <= acc + ACC_W'(prod);
        ST_Y1:  begin
          acc <= ACC_W'(prod);
          ax  <= abs_d;
        end
        ST_Y2, ST_Y3, ST_SQX: acc <= acc + ACC_W'(prod);
        ST_AY:  begin
          sq <= SQ_W'(prod[2*COORD_W-1:0]);
          ay <= abs_d;
        end
        ST_SUM: sq <= sq + SQ_W'(prod[2*COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  bfea_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sq),
    .busy     (root_busy),
    .done     (root_done),
    .root     (root_val)
  );

  // Saturating add of the distance to the running sum.
  always_comb begin
    sum_add = {1'b0, running_sum} + (SUM_W + 1)'(root_val);
    sum_sat = (sum_add >= {1'b0, SUM_MAX});
    sum_new = sum_sat ? SUM_MAX : sum_add[SUM_W-1:0];
  end

  // Sample capture with t clamped to one.
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      px     <= sample.point_x;
      py     <= sample.point_y;
      last_q <= sample.last;
      if (32'(sample.t_value) > 32'(T_ONE)) begin
        t_q <= T_ONE;
      end else begin
        t_q <= TW'(sample.t_value);
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (state == S_FINISH && last_q && out_free) begin
      result.error_sum <= sum_new;
      result.saturated <= overflow_seen || sum_sat;
    end
  end

  // Sequencer, sum state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= ST_UU;
      running_sum   <= '0;
      overflow_seen <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      // A beat taken in the same cycle as a new result is replaced by it below.
      if (result.valid && result.ready && !(state == S_FINISH && last_q)) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            state <= S_MUL;
            step  <= ST_UU;
          end
        end
        S_MUL: begin
          if (step == ST_ROOT) begin
            state <= S_ROOT;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_ROOT: begin
          if (root_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!last_q) begin
            running_sum   <= sum_new;
            overflow_seen <= overflow_seen || sum_sat;
            state         <= S_IDLE;
          end else if (out_free) begin
            running_sum   <= '0;
            overflow_seen <= 1'b0;
            result.valid  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Once saturated, the sum stays pinned at its maximum.
  a_flag_pins_sum: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> running_sum == SUM_MAX)
    else $error("overflow flag set with sum below maximum");

  a_result_sat: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |-> result.error_sum == SUM_MAX)
    else $error("saturated result without maximum sum");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> state == S_MUL && step == ST_UU)
    else $error("accepted sample did not start the sequencer");

  a_root_idle: assert property (@(posedge clk) disable iff (rst)
    root_start |-> !root_busy)
    else $error("square root started while busy");

  a_root_finish: assert property (@(posedge clk) disable iff (rst)
    state == S_ROOT && root_done |=> state == S_FINISH)
    else $error("square root completion missed");

endmodule

### rtl/core/bfea_mul.sv
// Shared signed multiplier with a registered product.
// Depends on bfea_pkg for the operand and product widths.
module bfea_mul import bfea_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### rtl/core/bfea_isqrt.sv
// Digit-by-digit floor square root, one radicand bit pair per cycle.
// Depends on bfea_pkg for the radicand and root widths.
module bfea_isqrt import bfea_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;

  // Bring down the next bit pair and try the subtraction.
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = {2'b00, root[ROOT_W-2:0], 2'b01};
    take   = (rem_sh >= trial);
  end

  // Control: counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: partial remainder and root.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rad  <= RAD_W'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= take ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], take};
    end
  end

endmodule
